// ===== rtl/core/eepp_pkg.sv =====
package eepp_pkg;

    // Coordinate format: signed fixed point, 10 fraction bits
    localparam int COORD_W  = 20;
    localparam int FIELD_W  = 60;
    localparam int RADIUS_W = 20;
    localparam int MARGIN_W = 20;
    localparam int TDATA_W  = 5 * FIELD_W + RADIUS_W;

    // Field slots in the input word, lowest first
    localparam int F_A_START = 0;
    localparam int F_A_END   = 1;
    localparam int F_B_START = 2;
    localparam int F_B_END   = 3;
    localparam int F_SHIFT   = 4;

    localparam int EA_W  = COORD_W + 1;
    localparam int V_W   = COORD_W + 2;
    localparam int RAD_W = MARGIN_W + 1;
    localparam int DOT_W = EA_W + V_W + 2;

    // Wide multiplier: signed MW x MW, built from NLIMB x NLIMB limb products
    localparam int LIMB_W  = 28;
    localparam int NLIMB   = 4;
    localparam int MW      = LIMB_W * NLIMB;
    localparam int PW      = 2 * MW;
    localparam int MUL_LAT = 7;

    localparam int FRONT_LAT = 3;
    localparam int PIPE_LAT  = FRONT_LAT + 3 * MUL_LAT + 4;

    localparam int EPS_RAW = 1;

    // Configuration space
    localparam int ADDR_W     = 3;
    localparam int REG_MARGIN = 0;

    typedef struct packed {
        logic [2:0][EA_W-1:0] ea;
        logic [2:0][EA_W-1:0] eb;
        logic [2:0][V_W-1:0]  v;
        logic [RAD_W-1:0]     rad;
    } t_side;

endpackage

// ===== rtl/core/edge_edge_proximity_test.sv =====
// Edge-edge proximity test. One request per cycle is taken on the s_axis side unless the
// pipeline holds, and one near flag per accepted request comes out on the m_axis side, in
// request order. The datapath is made of three passes through
// 7-stage wide limb multipliers (closest-point numerators, gap components, squares)
// plus the dot product front end and a few add and compare stages. The whole pipeline
// advances together and holds when the output register is full and not taken. The
// margin register (byte address 0) should be written only while the pipeline is empty.
module edge_edge_proximity_test (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // edge_a_start, edge_a_end, edge_b_start, edge_b_end, period_shift, radius_sum
    input  logic [eepp_pkg::TDATA_W-1:0]        s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // near
    output logic [7:0]                          m_axis_tdata,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [eepp_pkg::ADDR_W-1:0]         paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    localparam int MW    = eepp_pkg::MW;
    localparam int PW    = eepp_pkg::PW;
    localparam int LAT   = eepp_pkg::MUL_LAT;
    localparam int DOT_W = eepp_pkg::DOT_W;

    logic                             ce;
    logic                             reg_hit;
    logic [eepp_pkg::MARGIN_W-1:0]    r_margin;
    logic [eepp_pkg::PIPE_LAT-1:0]    r_vld;
    logic                             r_out_vld;
    logic                             r_near;

    logic signed [DOT_W-1:0] fc, fd, fe, fa, fb;
    eepp_pkg::t_side         f_side;
    eepp_pkg::t_side         r_side_dly [LAT];
    eepp_pkg::t_side         r4_side;
    eepp_pkg::t_side         r5_side;

    logic signed [PW-1:0] p_cd, p_ee, p_eb, p_ad, p_cb, p_ea;
    logic signed [MW-1:0] r4_f, r4_s, r4_t;
    logic signed [MW-1:0] r5_f, r5_s, r5_t;
    logic                 ok5;
    logic                 r_ok_a [LAT];
    logic                 r_ok_b [LAT+1];

    logic signed [PW-1:0] p_fv [3];
    logic signed [PW-1:0] p_se [3];
    logic signed [PW-1:0] p_tb [3];
    logic signed [PW-1:0] p_fr;
    logic signed [MW-1:0] r6_comp [3];
    logic signed [MW-1:0] r6_frad;
    logic signed [PW-1:0] p_sq [3];
    logic signed [PW-1:0] p_rhs;
    logic [PW-1:0]        r7_sum;
    logic [PW-1:0]        r7_rhs;
    logic                 r7_ok;

    assign ce            = !r_out_vld || m_axis_tready;
    assign s_axis_tready = ce;
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {7'b0, r_near};

    // configuration
    assign pready  = 1'b1;
    assign reg_hit = (paddr[eepp_pkg::ADDR_W-1:2] == (eepp_pkg::ADDR_W-2)'(eepp_pkg::REG_MARGIN));
    assign prdata  = reg_hit ? 32'(r_margin) : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_margin <= '0;
        end else if (psel && penable && pwrite && reg_hit) begin
            r_margin <= pwdata[eepp_pkg::MARGIN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (ce) begin
            r_vld     <= {r_vld[eepp_pkg::PIPE_LAT-2:0], s_axis_tvalid};
            r_out_vld <= r_vld[eepp_pkg::PIPE_LAT-1];
        end
    end

    eepp_front u_front (
        .i_clk    (i_clk),
        .i_ce     (ce),
        .i_tdata  (s_axis_tdata),
        .i_margin (r_margin),
        .o_c      (fc),
        .o_d      (fd),
        .o_e      (fe),
        .o_a      (fa),
        .o_b      (fb),
        .o_side   (f_side)
    );

    // numerators of s, t and the determinant
    eepp_mul u_mul_cd (.i_clk(i_clk), .i_ce(ce), .i_a(MW'(fc)), .i_b(MW'(fd)), .o_p(p_cd));
    eepp_mul u_mul_ee (.i_clk(i_clk), .i_ce(ce), .i_a(MW'(fe)), .i_b(MW'(fe)), .o_p(p_ee));
    eepp_mul u_mul_eb (.i_clk(i_clk), .i_ce(ce), .i_a(MW'(fe)), .i_b(MW'(fb)), .o_p(p_eb));
    eepp_mul u_mul_ad (.i_clk(i_clk), .i_ce(ce), .i_a(MW'(fa)), .i_b(MW'(fd)), .o_p(p_ad));
    eepp_mul u_mul_cb (.i_clk(i_clk), .i_ce(ce), .i_a(MW'(fc)), .i_b(MW'(fb)), .o_p(p_cb));
    eepp_mul u_mul_ea (.i_clk(i_clk), .i_ce(ce), .i_a(MW'(fe)), .i_b(MW'(fa)), .o_p(p_ea));

    // range and degeneracy checks on the sign-normalized values
    assign ok5 = (r5_f > MW'(eepp_pkg::EPS_RAW)) && !r5_s[MW-1] && (r5_s <= r5_f)
                 && !r5_t[MW-1] && (r5_t <= r5_f);

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_side_dly[0] <= f_side;
            for (int i = 1; i < LAT; i++) begin
                r_side_dly[i] <= r_side_dly[i-1];
            end
            r4_side <= r_side_dly[LAT-1];
            r4_f    <= MW'(p_cd - p_ee);
            r4_s    <= MW'(p_eb - p_ad);
            r4_t    <= MW'(p_cb - p_ea);

            // flip all three so the determinant is not negative
            r5_side <= r4_side;
            r5_f    <= r4_f[MW-1] ? -r4_f : r4_f;
            r5_s    <= r4_f[MW-1] ? -r4_s : r4_s;
            r5_t    <= r4_f[MW-1] ? -r4_t : r4_t;

            r_ok_a[0] <= ok5;
            r_ok_b[0] <= r_ok_a[LAT-1];
            for (int i = 1; i < LAT; i++) begin
                r_ok_a[i] <= r_ok_a[i-1];
                r_ok_b[i] <= r_ok_b[i-1];
            end
            r_ok_b[LAT] <= r_ok_b[LAT-1];

            for (int k = 0; k < 3; k++) begin
                r6_comp[k] <= MW'(p_fv[k] + p_se[k] - p_tb[k]);
            end
            r6_frad <= MW'(p_fr);

            r7_sum <= PW'(p_sq[0]) + PW'(p_sq[1]) + PW'(p_sq[2]);
            r7_rhs <= PW'(p_rhs);
            r7_ok  <= r_ok_b[LAT];

            r_near <= r7_ok && (r7_sum <= r7_rhs);
        end
    end

    // scaled gap between the closest points: F*v + S*Ea - T*Eb
    for (genvar k = 0; k < 3; k++) begin : g_gap
        eepp_mul u_mul_fv (
            .i_clk (i_clk), .i_ce (ce),
            .i_a (r5_f), .i_b (MW'($signed(r5_side.v[k]))), .o_p (p_fv[k])
        );
        eepp_mul u_mul_se (
            .i_clk (i_clk), .i_ce (ce),
            .i_a (r5_s), .i_b (MW'($signed(r5_side.ea[k]))), .o_p (p_se[k])
        );
        eepp_mul u_mul_tb (
            .i_clk (i_clk), .i_ce (ce),
            .i_a (r5_t), .i_b (MW'($signed(r5_side.eb[k]))), .o_p (p_tb[k])
        );
        eepp_mul u_mul_sq (
            .i_clk (i_clk), .i_ce (ce),
            .i_a (r6_comp[k]), .i_b (r6_comp[k]), .o_p (p_sq[k])
        );
    end

    eepp_mul u_mul_fr (
        .i_clk (i_clk), .i_ce (ce),
        .i_a (r5_f), .i_b (MW'(r5_side.rad)), .o_p (p_fr)
    );
    eepp_mul u_mul_rhs (
        .i_clk (i_clk), .i_ce (ce),
        .i_a (r6_frad), .i_b (r6_frad), .o_p (p_rhs)
    );

endmodule

// ===== rtl/core/eepp_mul.sv =====
module eepp_mul (
    input  logic                          i_clk,
    input  logic                          i_ce,
    input  logic signed [eepp_pkg::MW-1:0] i_a,
    input  logic signed [eepp_pkg::MW-1:0] i_b,
    output logic signed [eepp_pkg::PW-1:0] o_p
);

    localparam int L  = eepp_pkg::LIMB_W;
    localparam int N  = eepp_pkg::NLIMB;
    localparam int MW = eepp_pkg::MW;
    localparam int PW = eepp_pkg::PW;

    logic [MW-1:0]    r_ma;
    logic [MW-1:0]    r_mb;
    logic [5:0]       r_neg;
    logic [2*L-1:0]   r_pp   [N][N];
    logic [3*L-1:0]   r_half [N][2];
    logic [5*L-1:0]   r_row  [N];
    logic [6*L-1:0]   r_pair [2];
    logic [PW-1:0]    r_sum;
    logic signed [PW-1:0] r_p;

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_ma  <= i_a[MW-1] ? MW'(-i_a) : i_a;
            r_mb  <= i_b[MW-1] ? MW'(-i_b) : i_b;
            r_neg <= {r_neg[4:0], i_a[MW-1] ^ i_b[MW-1]};
            for (int i = 0; i < N; i++) begin
                for (int j = 0; j < N; j++) begin
                    r_pp[i][j] <= (2*L)'(r_ma[i*L +: L]) * (2*L)'(r_mb[j*L +: L]);
                end
            end
            for (int i = 0; i < N; i++) begin
                r_half[i][0] <= (3*L)'(r_pp[i][0]) + {r_pp[i][1], {L{1'b0}}};
                r_half[i][1] <= (3*L)'(r_pp[i][2]) + {r_pp[i][3], {L{1'b0}}};
                r_row[i]     <= (5*L)'(r_half[i][0]) + {r_half[i][1], {(2*L){1'b0}}};
            end
            r_pair[0] <= (6*L)'(r_row[0]) + {r_row[1], {L{1'b0}}};
            r_pair[1] <= (6*L)'(r_row[2]) + {r_row[3], {L{1'b0}}};
            r_sum     <= (8*L)'(r_pair[0]) + {r_pair[1], {(2*L){1'b0}}};
            r_p       <= r_neg[5] ? $signed(-r_sum) : $signed(r_sum);
        end
    end

    assign o_p = r_p;

endmodule

// ===== rtl/core/eepp_front.sv =====
module eepp_front (
    input  logic                                 i_clk,
    input  logic                                 i_ce,
    input  logic [eepp_pkg::TDATA_W-1:0]         i_tdata,
    input  logic [eepp_pkg::MARGIN_W-1:0]        i_margin,
    output logic signed [eepp_pkg::DOT_W-1:0]    o_c,
    output logic signed [eepp_pkg::DOT_W-1:0]    o_d,
    output logic signed [eepp_pkg::DOT_W-1:0]    o_e,
    output logic signed [eepp_pkg::DOT_W-1:0]    o_a,
    output logic signed [eepp_pkg::DOT_W-1:0]    o_b,
    output eepp_pkg::t_side                      o_side
);

    localparam int CW    = eepp_pkg::COORD_W;
    localparam int FW    = eepp_pkg::FIELD_W;
    localparam int EA_W  = eepp_pkg::EA_W;
    localparam int V_W   = eepp_pkg::V_W;
    localparam int DOT_W = eepp_pkg::DOT_W;
    localparam int RAD_W = eepp_pkg::RAD_W;

    logic signed [CW-1:0] a0 [3];
    logic signed [CW-1:0] a1 [3];
    logic signed [CW-1:0] b0 [3];
    logic signed [CW-1:0] b1 [3];
    logic signed [CW-1:0] sh [3];

    eepp_pkg::t_side r1_side;
    eepp_pkg::t_side r2_side;
    eepp_pkg::t_side r3_side;

    logic [2:0][2*EA_W-1:0]    r2_cc;
    logic [2:0][2*EA_W-1:0]    r2_dd;
    logic [2:0][2*EA_W-1:0]    r2_ee;
    logic [2:0][EA_W+V_W-1:0]  r2_aa;
    logic [2:0][EA_W+V_W-1:0]  r2_bb;

    logic signed [DOT_W-1:0] r3_c;
    logic signed [DOT_W-1:0] r3_d;
    logic signed [DOT_W-1:0] r3_e;
    logic signed [DOT_W-1:0] r3_a;
    logic signed [DOT_W-1:0] r3_b;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            a0[k] = $signed(i_tdata[eepp_pkg::F_A_START*FW + k*CW +: CW]);
            a1[k] = $signed(i_tdata[eepp_pkg::F_A_END*FW   + k*CW +: CW]);
            b0[k] = $signed(i_tdata[eepp_pkg::F_B_START*FW + k*CW +: CW]);
            b1[k] = $signed(i_tdata[eepp_pkg::F_B_END*FW   + k*CW +: CW]);
            sh[k] = $signed(i_tdata[eepp_pkg::F_SHIFT*FW   + k*CW +: CW]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            // edge vectors and start-to-start gap with the periodic shift
            for (int k = 0; k < 3; k++) begin
                r1_side.ea[k] <= EA_W'(a1[k]) - EA_W'(a0[k]);
                r1_side.eb[k] <= EA_W'(b1[k]) - EA_W'(b0[k]);
                r1_side.v[k]  <= V_W'(a0[k]) - V_W'(b0[k]) - V_W'(sh[k]);
            end
            r1_side.rad <= RAD_W'(i_tdata[5*FW +: eepp_pkg::RADIUS_W]) + RAD_W'(i_margin);

            r2_side <= r1_side;
            for (int k = 0; k < 3; k++) begin
                r2_cc[k] <= $signed(r1_side.ea[k]) * $signed(r1_side.ea[k]);
                r2_dd[k] <= $signed(r1_side.eb[k]) * $signed(r1_side.eb[k]);
                r2_ee[k] <= $signed(r1_side.ea[k]) * $signed(r1_side.eb[k]);
                r2_aa[k] <= $signed(r1_side.ea[k]) * $signed(r1_side.v[k]);
                r2_bb[k] <= $signed(r1_side.eb[k]) * $signed(r1_side.v[k]);
            end

            r3_side <= r2_side;
            r3_c <= DOT_W'($signed(r2_cc[0])) + DOT_W'($signed(r2_cc[1]))
                  + DOT_W'($signed(r2_cc[2]));
            r3_d <= DOT_W'($signed(r2_dd[0])) + DOT_W'($signed(r2_dd[1]))
                  + DOT_W'($signed(r2_dd[2]));
            r3_e <= DOT_W'($signed(r2_ee[0])) + DOT_W'($signed(r2_ee[1]))
                  + DOT_W'($signed(r2_ee[2]));
            r3_a <= DOT_W'($signed(r2_aa[0])) + DOT_W'($signed(r2_aa[1]))
                  + DOT_W'($signed(r2_aa[2]));
            r3_b <= DOT_W'($signed(r2_bb[0])) + DOT_W'($signed(r2_bb[1]))
                  + DOT_W'($signed(r2_bb[2]));
        end
    end

    assign o_c    = r3_c;
    assign o_d    = r3_d;
    assign o_e    = r3_e;
    assign o_a    = r3_a;
    assign o_b    = r3_b;
    assign o_side = r3_side;

endmodule

// ===== tb/tb.sv =====
module tb;
    import eepp_pkg::*;

    localparam int DRAIN_CYCLES = PIPE_LAT + 12;
    localparam int WATCHDOG_MAX = 3000;
    localparam int ITEMS_PER_PHASE = 540;
    localparam logic [1:0] EXP_FAR  = 2'd0;
    localparam logic [1:0] EXP_NEAR = 2'd1;
    localparam logic [1:0] EXP_CALC = 2'd2;

    typedef struct packed {
        logic [RADIUS_W-1:0] radius;
        logic [FIELD_W-1:0]  shift;
        logic [FIELD_W-1:0]  b_end;
        logic [FIELD_W-1:0]  b_start;
        logic [FIELD_W-1:0]  a_end;
        logic [FIELD_W-1:0]  a_start;
    } t_pair;

    typedef struct packed {
        t_pair      pair;
        logic [1:0] want;
    } t_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [TDATA_W-1:0]   s_axis_tdata;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [7:0]           m_axis_tdata;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_W-1:0]    paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;

    logic [MARGIN_W-1:0]  cur_margin;
    logic [1:0]           want_q[$];
    logic                 near_q[$];
    int                   errors;
    int                   sent;
    int                   seen_near;
    int                   seen_far;
    int                   idle_cycles;
    t_row                 rows[$];

    edge_edge_proximity_test dut (.*);

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    function automatic logic [FIELD_W-1:0] point(int x, int y, int z);
        logic [31:0] ux;
        logic [31:0] uy;
        logic [31:0] uz;
        ux = x;
        uy = y;
        uz = z;
        return {uz[COORD_W-1:0], uy[COORD_W-1:0], ux[COORD_W-1:0]};
    endfunction

    function automatic t_row mk_row(input logic [FIELD_W-1:0] a0, a1, b0, b1, sh,
                                    input logic [RADIUS_W-1:0] rad,
                                    input logic [1:0] want);
        t_row r;
        r.pair.a_start = a0;
        r.pair.a_end   = a1;
        r.pair.b_start = b0;
        r.pair.b_end   = b1;
        r.pair.shift   = sh;
        r.pair.radius  = rad;
        r.want         = want;
        return r;
    endfunction

    function automatic logic signed [255:0] wide(longint x);
        logic signed [255:0] r;
        r = x;
        return r;
    endfunction

    // exact closest-point test, division replaced by cross-multiplication
    function automatic logic edges_near(t_pair p, logic [MARGIN_W-1:0] mg);
        longint ea[3];
        longint eb[3];
        longint v[3];
        longint c, d, e, a, b, a0, a1, b0, b1, sh, rad;
        logic signed [255:0] f, s, t, sum, comp, rhs;
        c = 0; d = 0; e = 0; a = 0; b = 0;
        for (int k = 0; k < 3; k++) begin
            a0 = $signed(p.a_start[k*COORD_W +: COORD_W]);
            a1 = $signed(p.a_end[k*COORD_W +: COORD_W]);
            b0 = $signed(p.b_start[k*COORD_W +: COORD_W]);
            b1 = $signed(p.b_end[k*COORD_W +: COORD_W]);
            sh = $signed(p.shift[k*COORD_W +: COORD_W]);
            ea[k] = a1 - a0;
            eb[k] = b1 - b0;
            v[k] = a0 - b0 - sh;
        end
        for (int k = 0; k < 3; k++) begin
            c += ea[k] * ea[k];
            d += eb[k] * eb[k];
            e += ea[k] * eb[k];
            a += ea[k] * v[k];
            b += eb[k] * v[k];
        end
        f = wide(c) * wide(d) - wide(e) * wide(e);
        s = wide(e) * wide(b) - wide(a) * wide(d);
        t = wide(c) * wide(b) - wide(e) * wide(a);
        if (f < 0) begin
            f = -f;
            s = -s;
            t = -t;
        end
        if (!(f > EPS_RAW && s >= 0 && s <= f && t >= 0 && t <= f))
            return 1'b0;
        sum = 0;
        for (int k = 0; k < 3; k++) begin
            comp = f * wide(v[k]) + s * wide(ea[k]) - t * wide(eb[k]);
            sum = sum + comp * comp;
        end
        rad = longint'({44'd0, p.radius}) + longint'({44'd0, mg});
        rhs = f * f * (wide(rad) * wide(rad));
        return sum <= rhs;
    endfunction

    function automatic logic [FIELD_W-1:0] rand_field();
        return FIELD_W'({$urandom, $urandom});
    endfunction

    function automatic t_pair rand_pair();
        t_pair p;
        int r, mx, my, mz;
        if ($urandom_range(0, 4) == 0) begin
            p.a_start = rand_field();
            p.a_end   = rand_field();
            p.b_start = rand_field();
            p.b_end   = rand_field();
            p.shift   = rand_field();
            p.radius  = RADIUS_W'($urandom);
            return p;
        end
        // crossing edges around a shared middle, small offsets
        case ($urandom_range(0, 2))
            0: r = 64;
            1: r = 2048;
            default: r = 100000;
        endcase
        mx = $urandom_range(0, 2 * r) - r;
        my = $urandom_range(0, 2 * r) - r;
        mz = $urandom_range(0, 2 * r) - r;
        p.a_start = point(mx - $urandom_range(0, r), my + $urandom_range(0, r / 8) - r / 16,
                          mz + $urandom_range(0, r / 8) - r / 16);
        p.a_end   = point(mx + $urandom_range(0, r), my + $urandom_range(0, r / 8) - r / 16,
                          mz + $urandom_range(0, r / 8) - r / 16);
        p.b_start = point(mx + $urandom_range(0, r / 8) - r / 16, my - $urandom_range(0, r),
                          mz + $urandom_range(0, r / 4) - r / 8);
        p.b_end   = point(mx + $urandom_range(0, r / 8) - r / 16, my + $urandom_range(0, r),
                          mz + $urandom_range(0, r / 4) - r / 8);
        p.shift   = ($urandom_range(0, 2) == 0) ? point($urandom_range(0, 8) - 4,
                          $urandom_range(0, 8) - 4, $urandom_range(0, 2 * r) - r) : '0;
        p.radius  = RADIUS_W'($urandom_range(0, (r < 8191) ? r / 2 : 65535));
        return p;
    endfunction

    task automatic apb_write(logic [ADDR_W-1:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr[ADDR_W-1:2] == (ADDR_W-2)'(REG_MARGIN))
            cur_margin = data[MARGIN_W-1:0];
    endtask

    task automatic send_pair(t_pair p, logic [1:0] want);
        logic ok;
        want_q.push_back(want);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= p;
        forever begin
            @(negedge i_clk);
            ok = s_axis_tready;
            @(posedge i_clk);
            if (ok)
                break;
        end
        sent++;
    endtask

    task automatic wait_drained();
        while (near_q.size() != 0 || want_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic random_phase(int n, bit with_pause);
        int burst, gap;
        bit paused;
        paused = 1'b0;
        while (n > 0) begin
            burst = $urandom_range(1, 40);
            while (burst > 0 && n > 0) begin
                send_pair(rand_pair(), EXP_CALC);
                burst--;
                n--;
            end
            if (with_pause && !paused && n <= ITEMS_PER_PHASE / 2) begin
                paused = 1'b1;
                s_axis_tvalid <= 1'b0;
                while (near_q.size() != 0 || want_q.size() != 0)
                    @(posedge i_clk);
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b0;
    endtask

    // request side: attach the expectation on acceptance
    always @(posedge i_clk) begin
        logic [1:0] w;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            w = want_q.pop_front();
            if (w == EXP_CALC)
                near_q.push_back(edges_near(s_axis_tdata, cur_margin));
            else
                near_q.push_back(w == EXP_NEAR);
        end
    end

    // result side
    always @(posedge i_clk) begin
        logic exp_near;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (near_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time,
                         m_axis_tdata);
                errors++;
            end else begin
                exp_near = near_q.pop_front();
                if (m_axis_tdata !== {7'd0, exp_near}) begin
                    $display("%0t: near mismatch, expected %h, actual %h", $time,
                             {7'd0, exp_near}, m_axis_tdata);
                    errors++;
                end
                if (exp_near)
                    seen_near++;
                else
                    seen_far++;
            end
        end
    end

    // receiver stall pattern with one long hold-off while requests keep coming
    always @(posedge i_clk) begin
        int cnt;
        int mode;
        int hold_left;
        bit held;
        if (!i_rst_n) begin
            cnt = 0;
            hold_left = 0;
            held = 1'b0;
            m_axis_tready <= 1'b1;
        end else begin
            cnt++;
            if (cnt % 64 == 0)
                mode = $urandom_range(0, 3);
            if (!held && sent >= 300) begin
                held = 1'b1;
                hold_left = 250;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else case (mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= $urandom_range(0, 1);
                2: m_axis_tready <= ($urandom_range(0, 7) == 0);
                default: m_axis_tready <= (cnt % 5 != 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_MAX) begin
            $display("%0t: watchdog expired", $time);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        errors = 0;
        sent = 0;
        seen_near = 0;
        seen_far = 0;
        idle_cycles = 0;
        cur_margin = '0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;

        // crossing at the midpoints, gap zero
        rows.push_back(mk_row(point(0, 0, 0), point(2048, 0, 0), point(1024, -1024, 0),
                        point(1024, 1024, 0), 60'd0, 20'd0, EXP_NEAR));
        // gap of 1.0 along z: radius equal (inclusive) then one below
        rows.push_back(mk_row(point(0, 0, 0), point(2048, 0, 0), point(1024, -1024, 0),
                        point(1024, 1024, 0), point(0, 0, 1024), 20'd1024, EXP_NEAR));
        rows.push_back(mk_row(point(0, 0, 0), point(2048, 0, 0), point(1024, -1024, 0),
                        point(1024, 1024, 0), point(0, 0, 1024), 20'd1023, EXP_FAR));
        // degenerate: all zero, all ones, parallel edges
        rows.push_back(mk_row(60'd0, 60'd0, 60'd0, 60'd0, 60'd0, 20'hFFFFF, EXP_FAR));
        rows.push_back(mk_row({60{1'b1}}, {60{1'b1}}, {60{1'b1}}, {60{1'b1}}, {60{1'b1}},
                        20'hFFFFF, EXP_FAR));
        rows.push_back(mk_row(point(0, 0, 0), point(2048, 0, 0), point(0, 10, 0),
                        point(2048, 10, 0), 60'd0, 20'hFFFFF, EXP_FAR));
        // closest point beyond the end of edge A
        rows.push_back(mk_row(point(0, 0, 0), point(1024, 0, 0), point(4096, -1024, 0),
                        point(4096, 1024, 0), 60'd0, 20'hFFFFF, EXP_FAR));
        // closest points at the exact ends (s = 0, t = 1)
        rows.push_back(mk_row(point(0, 0, 0), point(2048, 0, 0), point(0, -2048, 0),
                        point(0, 0, 0), 60'd0, 20'd0, EXP_NEAR));
        // extreme coordinates
        rows.push_back(mk_row(point(-524288, -524288, -524288), point(524287, 524287, 524287),
                        point(524287, -524288, 0), point(-524288, 524287, 0),
                        point(-524288, 524287, -524288), 20'hFFFFF, EXP_CALC));
        rows.push_back(mk_row(point(524287, 0, 0), point(-524288, 0, 0), point(0, 524287, 0),
                        point(0, -524288, 0), point(524287, 524287, 524287), 20'd0,
                        EXP_CALC));
        rows.push_back(mk_row(point(-524288, 0, 0), point(524287, 1, 0), point(1, -524288, 1),
                        point(0, 524287, 0), 60'd0, 20'hFFFFF, EXP_CALC));
        // the plain midpoint crossing again, right after the extremes
        rows.push_back(mk_row(point(0, 0, 0), point(2048, 0, 0), point(1024, -1024, 0),
                        point(1024, 1024, 0), 60'd0, 20'd0, EXP_NEAR));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i])
            send_pair(rows[i].pair, rows[i].want);
        s_axis_tvalid <= 1'b0;
        random_phase(ITEMS_PER_PHASE, 1'b0);
        wait_drained();

        apb_write(ADDR_W'(4 * REG_MARGIN), 32'hFFFFFFFF);
        random_phase(ITEMS_PER_PHASE, 1'b0);
        wait_drained();

        apb_write(ADDR_W'(4 * REG_MARGIN), $urandom_range(0, 4096));
        random_phase(ITEMS_PER_PHASE, 1'b1);
        wait_drained();

        $display("Sent %0d edge pairs over margins zero, full scale and random;", sent);
        $display("results seen: %0d near, %0d not near.", seen_near, seen_far);
        if (errors == 0 && near_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/eepp_pkg.sv
rtl/core/eepp_mul.sv
rtl/core/eepp_front.sv
rtl/core/edge_edge_proximity_test.sv
tb/tb.sv
